>>> design/cau_pkg.sv
// Shared types, constants and helper functions for the complex arithmetic unit.
// Depends on nothing; every other file of the block uses it.
package cau_pkg;

    localparam int C_FRAC = 16;        // fraction bits of the Q format
    localparam int C_W    = 32;        // width of one operand or result part
    localparam int C_PW   = 2 * C_W;   // width of one product
    localparam int C_SW   = C_PW + 1;  // width of a sum of two products
    localparam int C_NW   = C_PW + C_FRAC;  // width of the scaled dividend
    localparam int C_STEPS = C_W;      // quotient bits, one per divider stage

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic signed [C_SW-1:0] C_SMAX = C_SW'(64'sd2147483647);
    localparam logic signed [C_SW-1:0] C_SMIN = C_SW'(-64'sd2147483648);
    localparam logic [C_W-1:0] C_PMAX = 32'h7FFF_FFFF;
    localparam logic [C_W-1:0] C_NMAX = 32'h8000_0000;

    typedef struct packed {
        logic           ovf;
        logic [C_W-1:0] val;
    } t_sat;

    typedef struct packed {
        logic [C_PW-1:0] rem;
        logic            q;
    } t_div_bit;

    // One item on its way through the divider stages.
    typedef struct packed {
        logic            is_div;
        logic            dz;
        logic [C_W-1:0]  pass_re;
        logic [C_W-1:0]  pass_im;
        logic            pass_ovf;
        logic            neg_re;
        logic            neg_im;
        logic            big_re;
        logic            big_im;
        logic [C_PW-1:0] den;
        logic [C_PW-1:0] rem_re;
        logic [C_PW-1:0] rem_im;
        logic [C_W-1:0]  lo_re;
        logic [C_W-1:0]  lo_im;
        logic [C_W-1:0]  quo_re;
        logic [C_W-1:0]  quo_im;
    } t_div_stage;

    typedef struct packed {
        logic [C_W-1:0] re;
        logic [C_W-1:0] im;
        logic           ovf;
        logic           dz;
    } t_result;

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic t_sat sat_wide(input logic signed [C_SW-1:0] v);
        t_sat r;
        if (v > C_SMAX) begin
            r.ovf = 1'b1;
            r.val = C_PMAX;
        end else if (v < C_SMIN) begin
            r.ovf = 1'b1;
            r.val = C_NMAX;
        end else begin
            r.ovf = 1'b0;
            r.val = v[C_W-1:0];
        end
        return r;
    endfunction

    // Clamp a sign and magnitude quotient; big marks a quotient beyond 32 bits.
    function automatic t_sat sat_mag(input logic neg, input logic big,
                                     input logic [C_W-1:0] mag);
        t_sat r;
        if (neg) begin
            if (big || mag > C_NMAX) begin
                r.ovf = 1'b1;
                r.val = C_NMAX;
            end else begin
                r.ovf = 1'b0;
                r.val = (~mag) + C_W'(1);
            end
        end else begin
            if (big || mag[C_W-1]) begin
                r.ovf = 1'b1;
                r.val = C_PMAX;
            end else begin
                r.ovf = 1'b0;
                r.val = mag;
            end
        end
        return r;
    endfunction

    // One restoring division step: shift in a dividend bit, subtract if it fits.
    function automatic t_div_bit div_bit(input logic [C_PW-1:0] rem, input logic nbit,
                                         input logic [C_PW-1:0] den);
        t_div_bit r;
        logic [C_PW:0] t;
        t = {rem, nbit};
        if (t >= {1'b0, den}) begin
            r.q   = 1'b1;
            r.rem = C_PW'(t - {1'b0, den});
        end else begin
            r.q   = 1'b0;
            r.rem = t[C_PW-1:0];
        end
        return r;
    endfunction

endpackage

>>> design/cau_if.sv
// Valid/ready channel interfaces for operand and result beats.
// Depends on cau_pkg for the part width.
interface cau_in_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic signed [cau_pkg::C_W-1:0] a_re;
    logic signed [cau_pkg::C_W-1:0] a_im;
    logic signed [cau_pkg::C_W-1:0] b_re;
    logic signed [cau_pkg::C_W-1:0] b_im;
    modport source (output valid, opcode, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, opcode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if;
    logic                      valid;
    logic                      ready;
    logic signed [cau_pkg::C_W-1:0] res_re;
    logic signed [cau_pkg::C_W-1:0] res_im;
    logic                      overflow;
    logic                      div_zero;
    modport source (output valid, res_re, res_im, overflow, div_zero, input ready);
    modport sink   (input valid, res_re, res_im, overflow, div_zero, output ready);
endinterface

>>> design/cau_front.sv
// Front end: products, sums of products, add/sub results and divider setup.
// Three register stages; depends on cau_pkg.
module cau_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_vld,
    input  logic [1:0]                     i_opcode,
    input  logic signed [cau_pkg::C_W-1:0] i_a_re,
    input  logic signed [cau_pkg::C_W-1:0] i_a_im,
    input  logic signed [cau_pkg::C_W-1:0] i_b_re,
    input  logic signed [cau_pkg::C_W-1:0] i_b_im,
    output logic                           o_vld,
    output cau_pkg::t_div_stage            o_stage
);

    // Stage 1: products
    logic                             r_vld1;
    logic [1:0]                       r_op1;
    logic                             r_dz1;
    logic signed [cau_pkg::C_PW-1:0]  r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_sq_r, r_sq_i;
    logic signed [cau_pkg::C_W:0]     r_as_re1, r_as_im1;

    // Stage 2: sums
    logic                             r_vld2;
    logic [1:0]                       r_op2;
    logic                             r_dz2;
    logic signed [cau_pkg::C_SW-1:0]  r_s_re, r_s_im;
    logic [cau_pkg::C_PW-1:0]         r_den;
    logic signed [cau_pkg::C_W:0]     r_as_re2, r_as_im2;

    // Stage 3: divider setup
    logic                             r_vld3;
    cau_pkg::t_div_stage              r_st3;
    cau_pkg::t_div_stage              n_st3;

    logic signed [cau_pkg::C_W:0]     n_as_re, n_as_im;
    logic signed [cau_pkg::C_SW-1:0]  n_s_re, n_s_im;

    always_comb begin
        if (i_opcode == cau_pkg::OP_SUB) begin
            n_as_re = {i_a_re[cau_pkg::C_W-1], i_a_re} - {i_b_re[cau_pkg::C_W-1], i_b_re};
            n_as_im = {i_a_im[cau_pkg::C_W-1], i_a_im} - {i_b_im[cau_pkg::C_W-1], i_b_im};
        end else begin
            n_as_re = {i_a_re[cau_pkg::C_W-1], i_a_re} + {i_b_re[cau_pkg::C_W-1], i_b_re};
            n_as_im = {i_a_im[cau_pkg::C_W-1], i_a_im} + {i_b_im[cau_pkg::C_W-1], i_b_im};
        end
    end

    always_comb begin
        if (r_op1 == cau_pkg::OP_DIV) begin
            n_s_re = cau_pkg::C_SW'(r_p_rr) + cau_pkg::C_SW'(r_p_ii);
            n_s_im = cau_pkg::C_SW'(r_p_ir) - cau_pkg::C_SW'(r_p_ri);
        end else begin
            n_s_re = cau_pkg::C_SW'(r_p_rr) - cau_pkg::C_SW'(r_p_ii);
            n_s_im = cau_pkg::C_SW'(r_p_ri) + cau_pkg::C_SW'(r_p_ir);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_en) begin
            r_vld1 <= i_vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op1    <= i_opcode;
            r_dz1    <= (i_b_re == '0) && (i_b_im == '0);
            r_p_rr   <= cau_pkg::C_PW'(i_a_re) * cau_pkg::C_PW'(i_b_re);
            r_p_ii   <= cau_pkg::C_PW'(i_a_im) * cau_pkg::C_PW'(i_b_im);
            r_p_ri   <= cau_pkg::C_PW'(i_a_re) * cau_pkg::C_PW'(i_b_im);
            r_p_ir   <= cau_pkg::C_PW'(i_a_im) * cau_pkg::C_PW'(i_b_re);
            r_sq_r   <= cau_pkg::C_PW'(i_b_re) * cau_pkg::C_PW'(i_b_re);
            r_sq_i   <= cau_pkg::C_PW'(i_b_im) * cau_pkg::C_PW'(i_b_im);
            r_as_re1 <= n_as_re;
            r_as_im1 <= n_as_im;

            r_op2    <= r_op1;
            r_dz2    <= r_dz1;
            r_s_re   <= n_s_re;
            r_s_im   <= n_s_im;
            r_den    <= $unsigned(r_sq_r) + $unsigned(r_sq_i);
            r_as_re2 <= r_as_re1;
            r_as_im2 <= r_as_im1;

            r_st3    <= n_st3;
        end
    end

    logic signed [cau_pkg::C_SW-1:0] w_sh_re, w_sh_im;
    logic [cau_pkg::C_SW-1:0]        w_neg_re, w_neg_im;
    logic [cau_pkg::C_PW-1:0]        w_mag_re, w_mag_im;
    logic [cau_pkg::C_NW-1:0]        w_n_re, w_n_im;
    logic [cau_pkg::C_PW-1:0]        w_top_re, w_top_im;
    cau_pkg::t_sat                   w_sat_re, w_sat_im;

    always_comb begin
        // The arithmetic shift floors the product sum, as the format needs.
        w_sh_re  = r_s_re >>> cau_pkg::C_FRAC;
        w_sh_im  = r_s_im >>> cau_pkg::C_FRAC;
        w_neg_re = -r_s_re;
        w_neg_im = -r_s_im;
        w_mag_re = r_s_re[cau_pkg::C_SW-1] ? w_neg_re[cau_pkg::C_PW-1:0]
                                           : r_s_re[cau_pkg::C_PW-1:0];
        w_mag_im = r_s_im[cau_pkg::C_SW-1] ? w_neg_im[cau_pkg::C_PW-1:0]
                                           : r_s_im[cau_pkg::C_PW-1:0];
        w_n_re   = {w_mag_re, {cau_pkg::C_FRAC{1'b0}}};
        w_n_im   = {w_mag_im, {cau_pkg::C_FRAC{1'b0}}};
        w_top_re = {{(cau_pkg::C_W - cau_pkg::C_FRAC){1'b0}},
                    w_n_re[cau_pkg::C_NW-1:cau_pkg::C_W]};
        w_top_im = {{(cau_pkg::C_W - cau_pkg::C_FRAC){1'b0}},
                    w_n_im[cau_pkg::C_NW-1:cau_pkg::C_W]};

        if (r_op2 == cau_pkg::OP_MUL) begin
            w_sat_re = cau_pkg::sat_wide(w_sh_re);
            w_sat_im = cau_pkg::sat_wide(w_sh_im);
        end else begin
            w_sat_re = cau_pkg::sat_wide(cau_pkg::C_SW'(r_as_re2));
            w_sat_im = cau_pkg::sat_wide(cau_pkg::C_SW'(r_as_im2));
        end

        n_st3.is_div   = (r_op2 == cau_pkg::OP_DIV);
        n_st3.dz       = r_dz2;
        n_st3.pass_re  = w_sat_re.val;
        n_st3.pass_im  = w_sat_im.val;
        n_st3.pass_ovf = w_sat_re.ovf | w_sat_im.ovf;
        n_st3.neg_re   = r_s_re[cau_pkg::C_SW-1];
        n_st3.neg_im   = r_s_im[cau_pkg::C_SW-1];
        // A quotient of 2^32 or more shows once the upper dividend reaches the divisor.
        n_st3.big_re   = (w_top_re >= r_den);
        n_st3.big_im   = (w_top_im >= r_den);
        n_st3.den      = r_den;
        n_st3.rem_re   = w_top_re;
        n_st3.rem_im   = w_top_im;
        n_st3.lo_re    = w_n_re[cau_pkg::C_W-1:0];
        n_st3.lo_im    = w_n_im[cau_pkg::C_W-1:0];
        n_st3.quo_re   = '0;
        n_st3.quo_im   = '0;
    end

    assign o_vld   = r_vld3;
    assign o_stage = r_st3;

endmodule

>>> design/cau_div_step.sv
// One registered stage of the restoring divider: one quotient bit per part.
// Depends on cau_pkg.
module cau_div_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  cau_pkg::t_div_stage i_stage,
    output logic                o_vld,
    output cau_pkg::t_div_stage o_stage
);

    logic                r_vld;
    cau_pkg::t_div_stage r_stage;
    cau_pkg::t_div_stage n_stage;
    cau_pkg::t_div_bit   w_re, w_im;

    always_comb begin
        w_re = cau_pkg::div_bit(i_stage.rem_re, i_stage.lo_re[cau_pkg::C_W-1], i_stage.den);
        w_im = cau_pkg::div_bit(i_stage.rem_im, i_stage.lo_im[cau_pkg::C_W-1], i_stage.den);
        n_stage        = i_stage;
        n_stage.rem_re = w_re.rem;
        n_stage.rem_im = w_im.rem;
        n_stage.lo_re  = {i_stage.lo_re[cau_pkg::C_W-2:0], 1'b0};
        n_stage.lo_im  = {i_stage.lo_im[cau_pkg::C_W-2:0], 1'b0};
        n_stage.quo_re = {i_stage.quo_re[cau_pkg::C_W-2:0], w_re.q};
        n_stage.quo_im = {i_stage.quo_im[cau_pkg::C_W-2:0], w_im.q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_stage <= n_stage;
        end
    end

    assign o_vld   = r_vld;
    assign o_stage = r_stage;

endmodule

>>> design/cau_back.sv
// Output stage: saturates the quotients and picks the result for the opcode.
// Depends on cau_pkg.
module cau_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  cau_pkg::t_div_stage i_stage,
    output logic                o_vld,
    output cau_pkg::t_result    o_res
);

    logic             r_vld;
    cau_pkg::t_result r_res;
    cau_pkg::t_result n_res;
    cau_pkg::t_sat    w_re, w_im;

    always_comb begin
        w_re = cau_pkg::sat_mag(i_stage.neg_re, i_stage.big_re, i_stage.quo_re);
        w_im = cau_pkg::sat_mag(i_stage.neg_im, i_stage.big_im, i_stage.quo_im);
        if (!i_stage.is_div) begin
            n_res.re  = i_stage.pass_re;
            n_res.im  = i_stage.pass_im;
            n_res.ovf = i_stage.pass_ovf;
            n_res.dz  = 1'b0;
        end else if (i_stage.dz) begin
            n_res.re  = '0;
            n_res.im  = '0;
            n_res.ovf = 1'b0;
            n_res.dz  = 1'b1;
        end else begin
            n_res.re  = w_re.val;
            n_res.im  = w_im.val;
            n_res.ovf = w_re.ovf | w_im.ovf;
            n_res.dz  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_vld = r_vld;
    assign o_res = r_res;

endmodule

>>> design/complex_arith_unit_core.sv
// Complex add, subtract, multiply and divide on signed Q16.16 operands. One beat
// is taken every cycle that the output is not held. The pipeline has three front
// stages (products, sums, divider setup), 32 divider stages that each settle one
// quotient bit, and one output stage. The whole pipeline advances together, so
// while the output beat is held it takes no new beat. Results saturate with an
// overflow flag; a zero divisor gives zero and the divide-by-zero flag.
module complex_arith_unit_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cau_in_if.sink    i_in,
    cau_out_if.source o_out
);

    logic                w_en;
    logic                w_vld [0:cau_pkg::C_STEPS];
    cau_pkg::t_div_stage w_stage [0:cau_pkg::C_STEPS];
    logic                w_out_vld;
    cau_pkg::t_result    w_res;

    assign w_en       = !w_out_vld || o_out.ready;
    assign i_in.ready = w_en;

    cau_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_vld    (i_in.valid),
        .i_opcode (i_in.opcode),
        .i_a_re   (i_in.a_re),
        .i_a_im   (i_in.a_im),
        .i_b_re   (i_in.b_re),
        .i_b_im   (i_in.b_im),
        .o_vld    (w_vld[0]),
        .o_stage  (w_stage[0])
    );

    for (genvar g = 0; g < cau_pkg::C_STEPS; g++) begin : g_div
        cau_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_vld[g]),
            .i_stage (w_stage[g]),
            .o_vld   (w_vld[g+1]),
            .o_stage (w_stage[g+1])
        );
    end

    cau_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_vld[cau_pkg::C_STEPS]),
        .i_stage (w_stage[cau_pkg::C_STEPS]),
        .o_vld   (w_out_vld),
        .o_res   (w_res)
    );

    assign o_out.valid    = w_out_vld;
    assign o_out.res_re   = w_res.re;
    assign o_out.res_im   = w_res.im;
    assign o_out.overflow = w_res.ovf;
    assign o_out.div_zero = w_res.dz;

`ifndef SYNTHESIS
    a_ready_follows_output : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready == (!o_out.valid || o_out.ready))
        else $error("input ready does not follow the output stall");

    a_div_zero_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.div_zero) |->
        (o_out.res_re == '0 && o_out.res_im == '0 && !o_out.overflow))
        else $error("divide-by-zero result is not a clean zero");

    a_overflow_saturates : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.overflow) |->
        (o_out.res_re == cau_pkg::C_PMAX || o_out.res_re == cau_pkg::C_NMAX ||
         o_out.res_im == cau_pkg::C_PMAX || o_out.res_im == cau_pkg::C_NMAX))
        else $error("overflow flagged without a saturated part");

    a_stall_holds_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_vld[cau_pkg::C_STEPS] && !w_en) |=> w_vld[cau_pkg::C_STEPS])
        else $error("divider output beat lost during a stall");
`endif

endmodule
